@@ hdl/mpas_pkg.sv @@
// Shared constants and types of the multipath active path selector.
`timescale 1ns / 1ps
`default_nettype none
package mpas_pkg;

  localparam int DEF_MAX_PATHS = 16;

  // Table entry: state above last-heard time
  localparam int TIME_W = 32;
  localparam int STATE_W = 2;
  localparam int ENT_W = STATE_W + TIME_W;

  typedef enum logic [1:0] {
    ST_INACTIVE,
    ST_ACTIVE,
    ST_UNCONFIRMED,
    ST_UNKNOWN
  } path_state_t;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_DOWN = 2'd2;

  localparam logic [1:0] NOTE_CONFIRMED   = 2'd0;
  localparam logic [1:0] NOTE_AVAILABLE   = 2'd1;
  localparam logic [1:0] NOTE_UNREACHABLE = 2'd2;

  localparam logic [1:0] CFG_PRIMARY_INDEX = 2'd0;
  localparam logic [1:0] CFG_PATHS_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_HB_SUCCESS    = 2'd2;

  localparam logic [3:0]  RST_PRIMARY_INDEX = 4'd0;
  localparam logic [4:0]  RST_PATHS_IN_USE  = 5'd1;
  localparam logic [15:0] RST_HB_SUCCESS    = 16'd2;

  // Per-entry request to the selection unit
  typedef struct packed {
    logic clear;
    logic step;
    logic usable;
    logic in_scope;
    logic is_primary;
  } sel_ctl_t;

  typedef struct packed {
    logic have_first;
    logic have_second;
    logic prim_usable;
  } sel_stat_t;

endpackage
`default_nettype wire

@@ hdl/mpas_if.sv @@
// Request channels of the path selector: command input and notification output.
`timescale 1ns / 1ps
`default_nettype none
interface mpas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  path_index;
  logic [1:0]  entry_state;
  logic [31:0] heard_time;
  logic [15:0] error_code;

  modport source (output valid, kind, path_index, entry_state, heard_time, error_code,
                  input ready);
  modport sink (input valid, kind, path_index, entry_state, heard_time, error_code,
                output ready);
endinterface

interface mpas_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  notify_state;
  logic [3:0]  notify_path;
  logic [15:0] notify_error;
  logic [3:0]  active_index;
  logic        retran_valid;
  logic [3:0]  retran_index;

  modport source (output valid, notify_state, notify_path, notify_error, active_index,
                  retran_valid, retran_index, input ready);
  modport sink (input valid, notify_state, notify_path, notify_error, active_index,
                retran_valid, retran_index, output ready);
endinterface
`default_nettype wire

@@ hdl/mpas_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mpas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/mpas_sel.sv @@
// Running choice of newest and second newest usable path during a table scan.
`timescale 1ns / 1ps
`default_nettype none
module mpas_sel #(
  parameter int MAX_PATHS = mpas_pkg::DEF_MAX_PATHS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mpas_pkg::sel_ctl_t           ctl,
  input  wire logic [$clog2(MAX_PATHS)-1:0] idx,
  input  wire logic [mpas_pkg::TIME_W-1:0]  heard,
  output logic      [$clog2(MAX_PATHS)-1:0] first,
  output logic      [$clog2(MAX_PATHS)-1:0] second,
  output mpas_pkg::sel_stat_t               stat
);
  import mpas_pkg::*;

  logic [TIME_W-1:0] first_t;
  logic [TIME_W-1:0] second_t;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      stat <= '0;
    end else if (ctl.step) begin
      if (ctl.is_primary) begin
        stat.prim_usable <= ctl.usable;
      end
      if (ctl.usable && ctl.in_scope) begin
        // strict compare keeps the earlier entry on a tie
        if (!stat.have_first || heard > first_t) begin
          second            <= first;
          second_t          <= first_t;
          stat.have_second  <= stat.have_first;
          first             <= idx;
          first_t           <= heard;
          stat.have_first   <= 1'b1;
        end else if (!stat.have_second || heard > second_t) begin
          second           <= idx;
          second_t         <= heard;
          stat.have_second <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/multipath_active_path_select_top.sv @@
// Top level of the multipath active path selector.
//
//  channel  | dir | request                                    | notes
//  ---------+-----+--------------------------------------------+---------------------------
//  in_ch    | in  | kind, path_index, entry_state, heard_time, | load, path up, path down
//           |     | error_code                                 |
//  out_ch   | out | notify_state, notify_path, notify_error,   | one per in-range up/down command
//           |     | active_index, retran_valid, retran_index   |
//  cfg_*    | in  | cfg_index, cfg_data under cfg_we           | primary, paths in use, hb
//
// A load writes its entry straight into the table. An up or down command runs from
// acceptance to the next free input as a read-modify-write of the named entry, then a
// scan of the path table memory at one entry per cycle, then the selection result.
// Reset is synchronous; valid bits per entry stand in for the cleared table, so no
// clearing pass is needed. The result sits in an output register; a stalled output
// holds back only the end of the following command.
`timescale 1ns / 1ps
`default_nettype none
module multipath_active_path_select_top #(
  parameter int MAX_PATHS = mpas_pkg::DEF_MAX_PATHS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  mpas_in_if.sink          in_ch,
  mpas_out_if.source       out_ch
);
  import mpas_pkg::*;

  localparam int IDX_W = $clog2(MAX_PATHS);
  localparam int CNT_W = $clog2(MAX_PATHS + 1);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_SCAN, S_DONE} fsm_t;

  fsm_t st;

  logic [3:0]  primary_index;
  logic [4:0]  paths_in_use;
  logic [15:0] hb_code;

  logic [1:0]       it_kind;
  logic [IDX_W-1:0] it_idx;
  logic [15:0]      it_err;
  logic [3:0]       it_path;
  logic [1:0]       note;

  logic [MAX_PATHS-1:0] ent_ok;
  logic                 rd_ok;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 proc_vld;
  logic [IDX_W-1:0]     proc_idx;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  logic              in_acc;
  logic              in_hit;
  logic [IDX_W-1:0]  in_addr;
  path_state_t       cur_state;
  logic [TIME_W-1:0] cur_time;
  path_state_t       new_state;
  logic [1:0]        new_note;
  logic              scan_last;

  sel_ctl_t         sctl;
  sel_stat_t        sstat;
  logic [IDX_W-1:0] sfirst;
  logic [IDX_W-1:0] ssecond;

  logic       bump;
  logic [3:0] fin_act;
  logic       fin_rv;
  logic [3:0] fin_rx;
  logic       out_free;

  assign in_ch.ready = (st == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_hit      = int'(in_ch.path_index) < MAX_PATHS;
  assign in_addr     = IDX_W'(in_ch.path_index);

  // Entry never written reads as inactive, heard at zero
  assign cur_state = rd_ok ? path_state_t'(ram_rdata[ENT_W-1:TIME_W]) : ST_INACTIVE;
  assign cur_time  = rd_ok ? ram_rdata[TIME_W-1:0] : '0;

  always_comb begin
    new_state = cur_state;
    new_note  = NOTE_UNREACHABLE;
    case (it_kind)
      KIND_UP: begin
        new_state = ST_ACTIVE;
        new_note  = (cur_state == ST_UNCONFIRMED && it_err == hb_code) ?
                    NOTE_CONFIRMED : NOTE_AVAILABLE;
      end
      KIND_DOWN: begin
        new_state = (cur_state == ST_UNCONFIRMED) ? ST_UNCONFIRMED : ST_INACTIVE;
        new_note  = NOTE_UNREACHABLE;
      end
      default: begin
        new_state = cur_state;
        new_note  = NOTE_UNREACHABLE;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    ram_wdata = {in_ch.entry_state, in_ch.heard_time};
    ram_raddr = in_addr;
    case (st)
      S_IDLE: begin
        ram_we = in_acc && in_hit && (in_ch.kind == KIND_LOAD);
      end
      S_MOD: begin
        ram_we    = 1'b1;
        ram_waddr = it_idx;
        ram_wdata = {new_state, cur_time};
      end
      S_SCAN: begin
        ram_raddr = issue_cnt[IDX_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mpas_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PATHS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign scan_last = proc_vld && (proc_idx == IDX_W'(MAX_PATHS - 1));

  always_comb begin
    sctl.clear      = (st == S_MOD);
    sctl.step       = (st == S_SCAN) && proc_vld;
    sctl.usable     = (cur_state == ST_ACTIVE) || (cur_state == ST_UNKNOWN);
    sctl.in_scope   = int'(proc_idx) < int'(paths_in_use);
    sctl.is_primary = int'(proc_idx) == int'(primary_index);
  end

  mpas_sel #(
    .MAX_PATHS (MAX_PATHS)
  ) u_sel (
    .clk    (clk),
    .rst    (rst),
    .ctl    (sctl),
    .idx    (proc_idx),
    .heard  (cur_time),
    .first  (sfirst),
    .second (ssecond),
    .stat   (sstat)
  );

  // Primary bump and fallback on the scan result
  always_comb begin
    bump = sstat.prim_usable &&
           (!sstat.have_first || int'(sfirst) != int'(primary_index));
    if (bump) begin
      fin_act = primary_index;
      fin_rv  = sstat.have_first;
      fin_rx  = sstat.have_first ? 4'(sfirst) : 4'd0;
    end else if (!sstat.have_first) begin
      fin_act = primary_index;
      fin_rv  = 1'b1;
      fin_rx  = primary_index;
    end else begin
      fin_act = 4'(sfirst);
      fin_rv  = sstat.have_second;
      fin_rx  = sstat.have_second ? 4'(ssecond) : 4'd0;
    end
  end

  assign out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_index <= RST_PRIMARY_INDEX;
      paths_in_use  <= RST_PATHS_IN_USE;
      hb_code       <= RST_HB_SUCCESS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRIMARY_INDEX: primary_index <= cfg_data[3:0];
        CFG_PATHS_IN_USE:  paths_in_use  <= cfg_data[4:0];
        CFG_HB_SUCCESS:    hb_code       <= cfg_data;
        default:           hb_code       <= hb_code;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= (int'(ram_raddr) < MAX_PATHS) && ent_ok[ram_raddr];
    if (rst) begin
      ent_ok <= '0;
    end else if (ram_we) begin
      ent_ok[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      out_ch.valid <= 1'b0;
      issue_cnt    <= '0;
      proc_vld     <= 1'b0;
    end else begin
      // in S_DONE the valid flag is set below when the output is free
      if (out_ch.valid && out_ch.ready && st != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          it_kind <= in_ch.kind;
          it_idx  <= in_addr;
          it_path <= in_ch.path_index;
          it_err  <= in_ch.error_code;
          if (in_acc && in_hit &&
              (in_ch.kind == KIND_UP || in_ch.kind == KIND_DOWN)) begin
            st <= S_MOD;
          end
        end
        S_MOD: begin
          note      <= new_note;
          issue_cnt <= '0;
          proc_vld  <= 1'b0;
          st        <= S_SCAN;
        end
        S_SCAN: begin
          if (issue_cnt != CNT_W'(MAX_PATHS)) begin
            proc_vld  <= 1'b1;
            proc_idx  <= issue_cnt[IDX_W-1:0];
            issue_cnt <= issue_cnt + CNT_W'(1);
          end else begin
            proc_vld <= 1'b0;
          end
          if (scan_last) begin
            st <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the previous notification has gone
          if (out_free) begin
            out_ch.valid        <= 1'b1;
            out_ch.notify_state <= note;
            out_ch.notify_path  <= it_path;
            out_ch.notify_error <= it_err;
            out_ch.active_index <= fin_act;
            out_ch.retran_valid <= fin_rv;
            out_ch.retran_index <= fin_rx;
            st                  <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/mpas_check.sv @@
// Port-level checks of the path selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mpas_check #(
  parameter int MAX_PATHS = mpas_pkg::DEF_MAX_PATHS
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_kind,
  input wire logic [3:0]  in_path_index,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  notify_state,
  input wire logic [3:0]  notify_path,
  input wire logic [15:0] notify_error,
  input wire logic [3:0]  active_index,
  input wire logic        retran_valid,
  input wire logic [3:0]  retran_index
);
  import mpas_pkg::*;

  // Stalled notification holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(notify_state) &&
      $stable(notify_path) && $stable(notify_error) && $stable(active_index) &&
      $stable(retran_valid) && $stable(retran_index))
    else $error("notification changed while stalled");

  // Without a retransmit choice its index reads zero
  a_retran_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !retran_valid |-> retran_index == 4'd0)
    else $error("retransmit index set without retransmit choice");

  // An accepted command occupies the block for the scan
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (int'(in_path_index) < MAX_PATHS) &&
      (in_kind == KIND_UP || in_kind == KIND_DOWN) |=> !in_ready)
    else $error("command accepted but block not busy");

  // A notification only appears at the end of a command
  a_note_from_cmd: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("notification without a command in progress");
endmodule

bind multipath_active_path_select_top mpas_check #(
  .MAX_PATHS (MAX_PATHS)
) u_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_kind       (in_ch.kind),
  .in_path_index (in_ch.path_index),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .notify_state  (out_ch.notify_state),
  .notify_path   (out_ch.notify_path),
  .notify_error  (out_ch.notify_error),
  .active_index  (out_ch.active_index),
  .retran_valid  (out_ch.retran_valid),
  .retran_index  (out_ch.retran_index)
);
`default_nettype wire
